// ===== rtl/pees_pkg.sv =====
// ----------------------------------------------------------------------------
// pees_pkg
// Shared types and constants of the pulse edge envelope sequencer.
// ----------------------------------------------------------------------------
package pees_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned DUR_W     = 10;
  localparam int unsigned PROD_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_AMP_STEP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_STEP1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUR_STEP0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUR_STEP1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_PAIRS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PLAT_PAIRS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TREMOLO_LEN = 3'd7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [7:0] AMP_MIN = 8'd16;
  localparam logic [7:0] AMP_MAX = 8'd239;
  localparam logic [7:0] DUR_MIN = 8'd6;
  localparam logic [7:0] DUR_MAX = 8'd239;

  // floor(x / 100) == (x * 83887) >> 23 for every x below 91180.
  localparam logic [16:0] SCALE_RECIP = 17'd83887;
  localparam int unsigned SCALE_SHIFT = 23;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_RISE = 4'b0010,
    PH_PLAT = 4'b0100,
    PH_FALL = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] amp_step0;
    logic [7:0] amp_step1;
    logic [7:0] dur_step0;
    logic [7:0] dur_step1;
    logic [7:0] repeat_count;
    logic [7:0] ramp_pairs;
    logic [7:0] plateau_pairs;
    logic [5:0] tremolo_len;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [7:0]        amp_a;
    logic [7:0]        amp_b;
    logic [PROD_W-1:0] prod_a;
    logic [PROD_W-1:0] prod_b;
  } item_t;

  typedef struct packed {
    logic [7:0] amplitude;
    logic [7:0] duration;
    logic       channel;
    logic       last;
  } edge_t;

endpackage

// ===== rtl/pees_dur_scale.sv =====
// ----------------------------------------------------------------------------
// pees_dur_scale
// Divides a scaled start duration product by 100 through a reciprocal
// multiplication.
// ----------------------------------------------------------------------------
module pees_dur_scale import pees_pkg::*; (
  input  logic [PROD_W-1:0] prod,
  output logic [DUR_W-1:0]  quot
);

  logic [PROD_W+16:0] full;

  assign full = {17'b0, prod} * {16'b0, SCALE_RECIP};
  assign quot = full[SCALE_SHIFT +: DUR_W];

endmodule

// ===== rtl/pees_core.sv =====
// ----------------------------------------------------------------------------
// pees_core
// Sequencer state and the single-pass edge computation for one beat.
// ----------------------------------------------------------------------------
module pees_core import pees_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  item_valid,
  input  logic  out_free,
  output logic  go,
  output logic  res_fire,
  output edge_t res
);

  localparam logic [1:0] SEEK_RISE = 2'd0;
  localparam logic [1:0] SEEK_PLAT = 2'd1;
  localparam logic [1:0] SEEK_FALL = 2'd2;
  localparam logic [1:0] SEEK_WRAP = 2'd3;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] reps;
    logic [7:0] pairs;
  } seek_t;

  function automatic seek_t seek(input logic [1:0] from, input logic [7:0] reps,
                                 input logic [7:0] ramp, input logic [7:0] plat);
    seek_t s;
    logic  rn;
    logic  pn;
    rn      = (ramp != 8'd0);
    pn      = (plat != 8'd0);
    s.phase = PH_IDLE;
    s.reps  = reps;
    s.pairs = ramp;
    if (reps == 8'd0) begin
      s.phase = PH_IDLE;
    end else if ((from == SEEK_RISE) && rn) begin
      s.phase = PH_RISE;
    end else if ((from == SEEK_RISE || from == SEEK_PLAT) && pn) begin
      s.phase = PH_PLAT;
      s.pairs = plat;
    end else if ((from != SEEK_WRAP) && rn) begin
      s.phase = PH_FALL;
    end else if (!rn && !pn) begin
      s.phase = PH_IDLE;
      s.reps  = 8'd0;
    end else begin
      s.reps = reps - 8'd1;
      if (reps == 8'd1) begin
        s.phase = PH_IDLE;
      end else if (rn) begin
        s.phase = PH_RISE;
      end else begin
        s.phase = PH_PLAT;
        s.pairs = plat;
      end
    end
    return s;
  endfunction

  logic [7:0]       amp_r [2];
  logic [DUR_W-1:0] dur_r [2];
  logic [7:0]       amp_nxt [2];
  logic [DUR_W-1:0] dur_nxt [2];
  logic [7:0]       reps_r, reps_nxt;
  logic [7:0]       pairs_r, pairs_nxt;
  logic [7:0]       trem_r, trem_nxt;
  logic             chan_r, chan_nxt;
  phase_t           phase_r, phase_nxt;

  logic [DUR_W-1:0] scaled_a, scaled_b;
  logic             produces;
  logic             ch;
  logic [7:0]       amp_cur, astep, dstep;
  logic [DUR_W-1:0] dur_cur, dur_new;
  logic [6:0]       half;
  logic [7:0]       full_per;
  logic [8:0]       cnt_inc;
  logic             lt;
  logic             amp_add;
  logic signed [9:0]  amp_sum;
  logic signed [11:0] dur_sum;
  logic [7:0]       amp_clamp, dur_clamp;
  logic [7:0]       pairs_dec;
  logic [1:0]       from_edge;
  seek_t            seek_start, seek_edge;

  pees_dur_scale u_scale_a (.prod(item.prod_a), .quot(scaled_a));
  pees_dur_scale u_scale_b (.prod(item.prod_b), .quot(scaled_b));

  assign produces = (item.command == CMD_STEP) && (phase_r != PH_IDLE);
  assign go       = item_valid && (!produces || out_free);
  assign res_fire = go && produces;

  always_comb begin
    ch       = chan_r;
    amp_cur  = amp_r[ch];
    dur_cur  = dur_r[ch];
    astep    = ch ? cfg.amp_step1 : cfg.amp_step0;
    dstep    = ch ? cfg.dur_step1 : cfg.dur_step0;
    half     = {cfg.tremolo_len, 1'b0};
    full_per = {cfg.tremolo_len, 2'b00};
    lt       = (trem_r < {1'b0, half});
    cnt_inc  = {1'b0, trem_r} + 9'd1;
    amp_add  = ((phase_r == PH_RISE) && !ch) || ((phase_r == PH_FALL) && ch) ||
               ((phase_r == PH_PLAT) && !lt);
    amp_sum  = amp_add ? $signed({2'b00, amp_cur}) + $signed({2'b00, astep})
                       : $signed({2'b00, amp_cur}) - $signed({2'b00, astep});
    if (amp_sum > $signed({2'b00, AMP_MAX})) begin
      amp_clamp = AMP_MAX;
    end else if (amp_sum < $signed({2'b00, AMP_MIN})) begin
      amp_clamp = AMP_MIN;
    end else begin
      amp_clamp = amp_sum[7:0];
    end
    dur_sum = lt ? $signed({2'b00, dur_cur}) + $signed({4'b0000, dstep})
                 : $signed({2'b00, dur_cur}) - $signed({4'b0000, dstep});
    if (dur_sum > $signed({4'b0000, DUR_MAX})) begin
      dur_clamp = DUR_MAX;
    end else if (dur_sum < $signed({4'b0000, DUR_MIN})) begin
      dur_clamp = DUR_MIN;
    end else begin
      dur_clamp = dur_sum[7:0];
    end
    dur_new   = (phase_r == PH_PLAT) ? {2'b00, dur_clamp} : dur_cur;
    pairs_dec = pairs_r - 8'd1;
    case (phase_r)
      PH_RISE: from_edge = SEEK_PLAT;
      PH_PLAT: from_edge = SEEK_FALL;
      default: from_edge = SEEK_WRAP;
    endcase
    seek_edge  = seek(from_edge, reps_r, cfg.ramp_pairs, cfg.plateau_pairs);
    seek_start = seek(SEEK_RISE, cfg.repeat_count, cfg.ramp_pairs, cfg.plateau_pairs);
  end

  always_comb begin
    amp_nxt   = amp_r;
    dur_nxt   = dur_r;
    reps_nxt  = reps_r;
    pairs_nxt = pairs_r;
    trem_nxt  = trem_r;
    chan_nxt  = chan_r;
    phase_nxt = phase_r;
    if (go && item.command == CMD_START) begin
      amp_nxt[0] = item.amp_a;
      amp_nxt[1] = item.amp_b;
      dur_nxt[0] = scaled_a;
      dur_nxt[1] = scaled_b;
      trem_nxt   = 8'd0;
      chan_nxt   = 1'b0;
      reps_nxt   = seek_start.reps;
      pairs_nxt  = seek_start.pairs;
      phase_nxt  = seek_start.phase;
    end else if (res_fire) begin
      amp_nxt[ch] = amp_clamp;
      dur_nxt[ch] = dur_new;
      if (phase_r == PH_PLAT) begin
        trem_nxt = (cnt_inc >= {1'b0, full_per}) ? 8'd0 : cnt_inc[7:0];
      end
      chan_nxt = ~ch;
      if (ch) begin
        pairs_nxt = pairs_dec;
        if (pairs_dec == 8'd0) begin
          reps_nxt  = seek_edge.reps;
          pairs_nxt = seek_edge.pairs;
          phase_nxt = seek_edge.phase;
          if (seek_edge.phase == PH_PLAT) begin
            trem_nxt = 8'd0;
          end
        end
      end
    end
  end

  always_comb begin
    res.amplitude = amp_clamp;
    res.duration  = dur_new[7:0];
    res.channel   = ch;
    res.last      = ch && (pairs_dec == 8'd0) && (seek_edge.phase == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r[0] <= '0;
      amp_r[1] <= '0;
      dur_r[0] <= '0;
      dur_r[1] <= '0;
      reps_r   <= '0;
      pairs_r  <= '0;
      trem_r   <= '0;
      chan_r   <= 1'b0;
      phase_r  <= PH_IDLE;
    end else begin
      amp_r   <= amp_nxt;
      dur_r   <= dur_nxt;
      reps_r  <= reps_nxt;
      pairs_r <= pairs_nxt;
      trem_r  <= trem_nxt;
      chan_r  <= chan_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/pulse_edge_envelope_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// pulse_edge_envelope_sequencer_top
// Two-channel pulse edge envelope sequencer with an input register, the
// sequencer core and an output register.
// ----------------------------------------------------------------------------
// Path: the input register holds a beat until the core takes it.
// Throughput: one beat per cycle unless the output stream stalls.
// Reset: synchronous, active low; the sequencer goes idle and the
// configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module pulse_edge_envelope_sequencer_top import pees_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // scale_percent, start_amp_a, start_amp_b, start_dur_a, start_dur_b
  input  logic [39:0]          in_tdata,
  // command
  input  logic [0:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // amplitude, duration
  output logic [15:0]          out_tdata,
  // channel
  output logic [0:0]           out_tuser,
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  item_t item_r;
  logic  item_valid_r;
  edge_t out_r;
  logic  out_valid_r;
  logic  go;
  logic  res_fire;
  logic  out_free;
  edge_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amp_step0     <= 8'd0;
      cfg_r.amp_step1     <= 8'd0;
      cfg_r.dur_step0     <= 8'd0;
      cfg_r.dur_step1     <= 8'd0;
      cfg_r.repeat_count  <= 8'd1;
      cfg_r.ramp_pairs    <= 8'd1;
      cfg_r.plateau_pairs <= 8'd1;
      cfg_r.tremolo_len   <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMP_STEP0:   cfg_r.amp_step0     <= cfg_wdata;
        REG_AMP_STEP1:   cfg_r.amp_step1     <= cfg_wdata;
        REG_DUR_STEP0:   cfg_r.dur_step0     <= cfg_wdata;
        REG_DUR_STEP1:   cfg_r.dur_step1     <= cfg_wdata;
        REG_REPEAT_CNT:  cfg_r.repeat_count  <= cfg_wdata;
        REG_RAMP_PAIRS:  cfg_r.ramp_pairs    <= cfg_wdata;
        REG_PLAT_PAIRS:  cfg_r.plateau_pairs <= cfg_wdata;
        REG_TREMOLO_LEN: cfg_r.tremolo_len   <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_valid_r <= 1'b1;
    end else if (go) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.command <= in_tuser[0];
      item_r.amp_a   <= in_tdata[15:8];
      item_r.amp_b   <= in_tdata[23:16];
      item_r.prod_a  <= {8'b0, in_tdata[7:0]} * {8'b0, in_tdata[31:24]};
      item_r.prod_b  <= {8'b0, in_tdata[7:0]} * {8'b0, in_tdata[39:32]};
    end
  end

  pees_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item      (item_r),
    .item_valid(item_valid_r),
    .out_free  (out_free),
    .go        (go),
    .res_fire  (res_fire),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_r.duration, out_r.amplitude};
  assign out_tuser[0] = out_r.channel;
  assign out_tlast    = out_r.last;

endmodule

// ===== tb/pulse_edge_envelope_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// pulse_edge_envelope_sequencer_checker
// Watches the register port and both streams of the envelope sequencer. It
// keeps its own copy of the registers and of the envelope state, predicts
// the edge produced by every accepted beat, and compares each output beat
// with the oldest predicted edge.
// ----------------------------------------------------------------------------
module pulse_edge_envelope_sequencer_checker import pees_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  // scale_percent, start_amp_a, start_amp_b, start_dur_a, start_dur_b
  input  logic [39:0]          in_tdata,
  // command
  input  logic [0:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  // amplitude, duration
  input  logic [15:0]          out_tdata,
  // channel
  input  logic [0:0]           out_tuser,
  input  logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   mismatches,
  output int                   pending,
  output int                   edges_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t       regs;
  logic [7:0] lvl_amp [2];
  logic [9:0] lvl_dur [2];
  logic [7:0] reps_left;
  phase_t     stage;
  logic [7:0] pairs_left;
  logic       chan;
  logic [7:0] trem_cnt;
  edge_t      edge_q [$];
  int         err_cnt = 0;
  int         seen_cnt = 0;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic phase_t following_stage(phase_t p);
    case (p)
      PH_RISE: return PH_PLAT;
      PH_PLAT: return PH_FALL;
      default: return PH_IDLE;
    endcase
  endfunction

  // Enters the first non-empty stage at or after the given one; an idle
  // stage stands for the end of one repeat.
  task automatic enter_stage(input phase_t first);
    phase_t     p;
    logic [7:0] n;
    bit         done;
    p = first;
    done = 1'b0;
    while (!done) begin
      if (reps_left == 8'd0) begin
        stage = PH_IDLE;
        done = 1'b1;
      end else if (p == PH_IDLE) begin
        reps_left = reps_left - 8'd1;
        p = PH_RISE;
      end else begin
        n = (p == PH_PLAT) ? regs.plateau_pairs : regs.ramp_pairs;
        if (n != 8'd0) begin
          stage = p;
          pairs_left = n;
          chan = 1'b0;
          if (p == PH_PLAT) trem_cnt = 8'd0;
          done = 1'b1;
        end else begin
          p = following_stage(p);
        end
      end
    end
  endtask

  task automatic advance_envelope(input logic cmd, input logic [39:0] data);
    int    sc, da, db, amp, dur, astep, dstep, half, cnt;
    logic  ch;
    edge_t e;
    if (cmd == CMD_START) begin
      sc = data[7:0];
      da = data[31:24];
      db = data[39:32];
      lvl_amp[0] = data[15:8];
      lvl_amp[1] = data[23:16];
      lvl_dur[0] = 10'((sc * da) / 100);
      lvl_dur[1] = 10'((sc * db) / 100);
      reps_left = regs.repeat_count;
      trem_cnt = 8'd0;
      enter_stage(PH_RISE);
    end else if (stage != PH_IDLE) begin
      ch = chan;
      amp = lvl_amp[ch];
      dur = lvl_dur[ch];
      astep = ch ? regs.amp_step1 : regs.amp_step0;
      dstep = ch ? regs.dur_step1 : regs.dur_step0;
      case (stage)
        PH_RISE: amp = clamp_to(ch ? amp - astep : amp + astep, AMP_MIN, AMP_MAX);
        PH_FALL: amp = clamp_to(ch ? amp + astep : amp - astep, AMP_MIN, AMP_MAX);
        default: begin
          half = regs.tremolo_len;
          half = 2 * half;
          cnt = trem_cnt;
          if (cnt < half) begin
            dur = dur + dstep;
            amp = amp - astep;
          end else begin
            dur = dur - dstep;
            amp = amp + astep;
          end
          cnt = cnt + 1;
          if (cnt >= 2 * half) cnt = 0;
          trem_cnt = cnt[7:0];
          amp = clamp_to(amp, AMP_MIN, AMP_MAX);
          dur = clamp_to(dur, DUR_MIN, DUR_MAX);
        end
      endcase
      lvl_amp[ch] = amp[7:0];
      lvl_dur[ch] = dur[9:0];
      if (!ch) begin
        chan = 1'b1;
      end else begin
        chan = 1'b0;
        pairs_left = pairs_left - 8'd1;
        if (pairs_left == 8'd0) enter_stage(following_stage(stage));
      end
      e.amplitude = amp[7:0];
      e.duration = dur[7:0];
      e.channel = ch;
      e.last = (stage == PH_IDLE);
      edge_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    edge_t got;
    edge_t want;
    if (!rst_n) begin
      regs = '{amp_step0: 8'd0, amp_step1: 8'd0, dur_step0: 8'd0, dur_step1: 8'd0,
               repeat_count: 8'd1, ramp_pairs: 8'd1, plateau_pairs: 8'd1,
               tremolo_len: 6'd1};
      lvl_amp[0] = 8'd0;
      lvl_amp[1] = 8'd0;
      lvl_dur[0] = 10'd0;
      lvl_dur[1] = 10'd0;
      reps_left = 8'd0;
      stage = PH_IDLE;
      pairs_left = 8'd0;
      chan = 1'b0;
      trem_cnt = 8'd0;
      edge_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AMP_STEP0:   regs.amp_step0 = cfg_wdata;
          REG_AMP_STEP1:   regs.amp_step1 = cfg_wdata;
          REG_DUR_STEP0:   regs.dur_step0 = cfg_wdata;
          REG_DUR_STEP1:   regs.dur_step1 = cfg_wdata;
          REG_REPEAT_CNT:  regs.repeat_count = cfg_wdata;
          REG_RAMP_PAIRS:  regs.ramp_pairs = cfg_wdata;
          REG_PLAT_PAIRS:  regs.plateau_pairs = cfg_wdata;
          REG_TREMOLO_LEN: regs.tremolo_len = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.amplitude = out_tdata[7:0];
        got.duration = out_tdata[15:8];
        got.channel = out_tuser[0];
        got.last = out_tlast;
        seen_cnt++;
        if (edge_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected edge: amp %0d dur %0d ch %0d last %0d",
                   $time, got.amplitude, got.duration, got.channel, got.last);
        end else begin
          want = edge_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%0t: edge mismatch: expected amp %0d dur %0d ch %0d last %0d,",
                     $time, want.amplitude, want.duration, want.channel, want.last,
                     " actual amp %0d dur %0d ch %0d last %0d",
                     got.amplitude, got.duration, got.channel, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) advance_envelope(in_tuser[0], in_tdata);
    end
    pending <= edge_q.size();
    mismatches <= err_cnt;
    edges_checked <= seen_cnt;
  end

endmodule

// ===== tb/pulse_edge_envelope_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// pulse_edge_envelope_sequencer_top_tb
// Drives the envelope sequencer with a directed opening and then random
// start and step sequences under a series of register settings, with random
// stalls on both streams. A separate checker predicts and compares every
// edge; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module pulse_edge_envelope_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pees_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int LIMIT        = 200000;
  localparam int TARGET_ITEMS = 450;
  localparam int SETTLE       = 4;
  localparam int MAX_EDGES    = 48;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata = '0;
  logic [0:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;
  logic [0:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  int mismatches;
  int pending;
  int edges_checked;
  int cycles = 0;
  int stall_left = 0;
  bit idling = 1'b1;
  int beats_sent = 0;
  int useful_items = 0;
  int settings_used = 0;

  pulse_edge_envelope_sequencer_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pulse_edge_envelope_sequencer_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .edges_checked(edges_checked)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: timeout with %0d edges outstanding", $time, pending);
      $display("** pulse_edge_envelope_sequencer_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [39:0] start_word(input logic [7:0] scale, input logic [7:0] amp_a,
                                             input logic [7:0] amp_b, input logic [7:0] dur_a,
                                             input logic [7:0] dur_b);
    return {dur_b, dur_a, amp_b, amp_a, scale};
  endfunction

  task automatic wait_results(input int extra);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic send_beat(input logic cmd, input logic [39:0] data);
    bit pause;
    bit gap;
    pause = idling && ($urandom_range(0, 60) == 0);
    gap = idling && ($urandom_range(0, 4) == 0);
    if (pause || gap) begin
      in_tvalid <= 1'b0;
      if (pause) wait_results(0);
      if (gap) repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic step_beat();
    send_beat(CMD_STEP, 40'({$urandom(), $urandom()}));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input cfg_t c);
    in_tvalid <= 1'b0;
    wait_results(SETTLE);
    write_reg(REG_AMP_STEP0, c.amp_step0);
    write_reg(REG_AMP_STEP1, c.amp_step1);
    write_reg(REG_DUR_STEP0, c.dur_step0);
    write_reg(REG_DUR_STEP1, c.dur_step1);
    write_reg(REG_REPEAT_CNT, c.repeat_count);
    write_reg(REG_RAMP_PAIRS, c.ramp_pairs);
    write_reg(REG_PLAT_PAIRS, c.plateau_pairs);
    write_reg(REG_TREMOLO_LEN, {2'($urandom()), c.tremolo_len});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_step();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40));
  endfunction

  function automatic logic [7:0] pick_extreme(input int hi);
    return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(hi);
  endfunction

  function automatic cfg_t pick_cfg(input bit extreme);
    cfg_t c;
    if (extreme) begin
      c.amp_step0 = pick_extreme(255);
      c.amp_step1 = pick_extreme(255);
      c.dur_step0 = pick_extreme(255);
      c.dur_step1 = pick_extreme(255);
      c.repeat_count = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd255;
      c.ramp_pairs = pick_extreme(255);
      c.plateau_pairs = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd255;
      c.tremolo_len = 6'(pick_extreme(63));
    end else begin
      c.amp_step0 = pick_step();
      c.amp_step1 = pick_step();
      c.dur_step0 = pick_step();
      c.dur_step1 = pick_step();
      c.repeat_count = 8'($urandom_range(0, 8) == 0 ? 0 : $urandom_range(1, 3));
      c.ramp_pairs = 8'($urandom_range(0, 4));
      c.plateau_pairs = 8'($urandom_range(0, 6));
      c.tremolo_len = 6'($urandom_range(0, 5));
    end
    return c;
  endfunction

  // One start, sometimes after a stray step, followed by steps; sometimes cut
  // short, sometimes run past the final edge.
  task automatic run_sequence(input cfg_t c);
    int total;
    int steps;
    int useful;
    total = c.repeat_count * (4 * c.ramp_pairs + 2 * c.plateau_pairs);
    if (total > MAX_EDGES) total = MAX_EDGES;
    if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, total);
    else steps = total + $urandom_range(0, 2);
    if ($urandom_range(0, 9) == 0) step_beat();
    send_beat(CMD_START, 40'({$urandom(), $urandom()}));
    useful_items++;
    for (int i = 0; i < steps; i++) begin
      step_beat();
      if (i < total) useful_items++;
    end
  endtask

  initial begin
    cfg_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    step_beat();

    c = '{amp_step0: 8'd255, amp_step1: 8'd255, dur_step0: 8'd255, dur_step1: 8'd255,
          repeat_count: 8'd1, ramp_pairs: 8'd1, plateau_pairs: 8'd2, tremolo_len: 6'd0};
    program_regs(c);
    send_beat(CMD_START, start_word(8'd255, 8'd255, 8'd0, 8'd255, 8'd255));
    repeat (9) step_beat();

    c = '{amp_step0: 8'd1, amp_step1: 8'd2, dur_step0: 8'd3, dur_step1: 8'd4,
          repeat_count: 8'd0, ramp_pairs: 8'd2, plateau_pairs: 8'd1, tremolo_len: 6'd63};
    program_regs(c);
    send_beat(CMD_START, start_word(8'd100, 8'd128, 8'd128, 8'd50, 8'd60));
    step_beat();

    c.repeat_count = 8'd2;
    c.ramp_pairs = 8'd0;
    c.plateau_pairs = 8'd0;
    program_regs(c);
    send_beat(CMD_START, start_word(8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
    step_beat();

    c.plateau_pairs = 8'd1;
    program_regs(c);
    send_beat(CMD_START, start_word(8'd0, 8'd0, 8'd255, 8'd0, 8'd0));
    repeat (2) step_beat();
    send_beat(CMD_START, start_word(8'd170, 8'd85, 8'd170, 8'd200, 8'd7));
    repeat (5) step_beat();

    while (useful_items < TARGET_ITEMS) begin
      c = pick_cfg(settings_used % 4 == 3);
      program_regs(c);
      if (useful_items > TARGET_ITEMS - 70) idling = 1'b0;
      else idling = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) run_sequence(c);
    end

    in_tvalid <= 1'b0;
    wait_results(10);
    $display("Sent %0d beats under %0d register settings; %0d edges were compared.",
             beats_sent, settings_used, edges_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("** pulse_edge_envelope_sequencer_top: PASSED **");
    end else begin
      $display("** pulse_edge_envelope_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
